@@ src/tpd_pkg.sv @@
package tpd_pkg;

   localparam int REPORT_LEN       = 8;
   localparam int NUM_KEYS_DEFAULT = 3;
   localparam int MAX_RES          = 3;
   localparam int QUEUE_DEPTH      = 2;
   localparam int QPTR_W           = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0]  HDR_BYTE       = 8'h52;
   localparam logic [7:0]  FILL_BYTE      = 8'hff;
   localparam logic [7:0]  THRESHOLD_RST  = 8'd5;
   localparam logic [15:0] TIMEOUT_RST    = 16'd333;
   localparam logic [11:0] Y_MAX_RST      = 12'd2047;

   localparam logic [1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_TIMEOUT   = 2'd1;
   localparam logic [1:0] CSR_Y_MAX     = 2'd2;

   typedef enum logic [2:0] {
      CMD_TICK,
      CMD_ERROR,
      CMD_TOUCH,
      CMD_RELEASE,
      CMD_BUTTON
   } cmd_op_type;

   typedef enum logic [1:0] {
      EV_PRESS   = 2'd0,
      EV_RELEASE = 2'd1,
      EV_KEY     = 2'd2,
      EV_ERROR   = 2'd3
   } event_kind_type;

   // data[0] holds report byte 1, data[5] report byte 6
   typedef struct packed {
      cmd_op_type      op;
      logic [5:0][7:0] data;
   } cmd_type;

   typedef struct packed {
      logic              valid;
      logic              full;
      logic [QCNT_W-1:0] count;
   } q_stat_type;

   typedef struct packed {
      logic [7:0]  threshold;
      logic [15:0] timeout;
      logic [11:0] y_max;
   } cfg_type;

   typedef struct packed {
      event_kind_type kind;
      logic           finger;
      logic [12:0]    x;
      logic [15:0]    y;
      logic [1:0]     key;
      logic           last;
   } res_type;

endpackage

@@ src/tpd_front.sv @@
module tpd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic             opcode,
   input  logic [7:0]       packet_byte,
   input  logic             packet_start,
   output logic             push,
   output tpd_pkg::cmd_type cmd
);
   import tpd_pkg::*;

   localparam logic [2:0] LAST_POS = 3'(REPORT_LEN - 1);

   logic [2:0] byte_pos_ff, byte_pos_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] bytes_ff [REPORT_LEN-1];
   logic [2:0] pos;
   logic       hdr_ok;
   logic       fill_pattern;

   assign pos = packet_start ? 3'd0 : byte_pos_ff;

   always_comb begin
      byte_pos_in = byte_pos_ff;
      sum_in      = sum_ff;
      if (accept && !opcode) begin
         byte_pos_in = (pos == LAST_POS) ? 3'd0 : pos + 3'd1;
         if (pos == 3'd0) begin
            sum_in = packet_byte;
         end else if (pos != LAST_POS) begin
            sum_in = sum_ff + packet_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff <= '0;
         sum_ff      <= '0;
      end else begin
         byte_pos_ff <= byte_pos_in;
         sum_ff      <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !opcode && pos != LAST_POS) begin
         bytes_ff[pos] <= packet_byte;
      end
   end

   assign hdr_ok = (bytes_ff[0] == HDR_BYTE) && ((8'd0 - sum_ff) == packet_byte);
   assign fill_pattern = (bytes_ff[1] == FILL_BYTE) && (bytes_ff[2] == FILL_BYTE)
                      && (bytes_ff[3] == FILL_BYTE) && (bytes_ff[4] == 8'h00)
                      && (bytes_ff[6] == FILL_BYTE);

   always_comb begin
      push = accept && (opcode || pos == LAST_POS);
      for (int i = 0; i < 6; i++) begin
         cmd.data[i] = bytes_ff[i + 1];
      end
      if (opcode) begin
         cmd.op = CMD_TICK;
      end else if (!hdr_ok) begin
         cmd.op = CMD_ERROR;
      end else if (fill_pattern) begin
         cmd.op = (bytes_ff[5] != 8'h00) ? CMD_BUTTON : CMD_RELEASE;
      end else begin
         cmd.op = CMD_TOUCH;
      end
   end

endmodule

@@ src/tpd_queue.sv @@
module tpd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tpd_pkg::cmd_type    push_cmd,
   input  logic                pop,
   output tpd_pkg::cmd_type    head,
   output tpd_pkg::q_stat_type stat
);
   import tpd_pkg::*;

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign stat.valid = (count_ff != '0);
   assign stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign stat.count = count_ff;
   assign head       = entry_ff[rd_ptr_ff];

   assign do_push = push && !stat.full;
   assign do_pop  = pop && stat.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ src/tpd_back.sv @@
module tpd_back #(
   parameter int NUM_KEYS = tpd_pkg::NUM_KEYS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  tpd_pkg::cfg_type cfg,
   input  logic             head_valid,
   input  tpd_pkg::cmd_type head,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tpd_pkg::res_type rsp
);
   import tpd_pkg::*;

   logic                     step_ff, step_in;
   logic                     phase_ff, phase_in;
   logic [NUM_KEYS-1:0]      pend_ff, pend_in;
   logic [NUM_KEYS-1:0][7:0] cnt_ff, cnt_in;
   logic [NUM_KEYS-1:0]      flag_ff, flag_in;
   logic [15:0]              timer_ff, timer_in;
   logic [1:0]               fcount_ff, fcount_in;
   logic [12:0]              sx_ff [2];
   logic [15:0]              sy_ff [2];
   logic                     rsp_valid_ff;
   res_type                  rsp_ff;

   logic                     out_free, emit, store_pts;
   res_type                  res;

   logic [11:0] x0, y0, x1r, y1r, mag;
   logic [12:0] x1;
   logic [15:0] y1d, py0, py1;
   logic        two;

   logic [NUM_KEYS-1:0][7:0] cnt_next;
   logic [NUM_KEYS-1:0]      hit, ev_mask, low, rest;
   logic [1:0]               taken;
   logic [1:0]               kidx;
   logic [7:0]               key_bits;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // touch decode
   assign x0  = {head.data[0][7:4], head.data[1]};
   assign y0  = {head.data[0][3:0], head.data[2]};
   assign x1r = {head.data[3][7:4], head.data[4]};
   assign y1r = {head.data[3][3:0], head.data[5]};
   assign two = (x1r != '0) || (y1r != '0);
   assign x1  = {1'b0, x1r} + {1'b0, x0};
   assign mag = {1'b0, ~y1r[10:0]} + 12'd1;
   assign y1d = y1r[11] ? ({4'b0, y0} - {4'b0, mag}) : ({4'b0, y1r} + {4'b0, y0});
   assign py0 = {4'b0, cfg.y_max} - {4'b0, y0};
   assign py1 = {4'b0, cfg.y_max} - y1d;

   // button decode
   assign key_bits = head.data[4];
   always_comb begin
      taken   = '0;
      ev_mask = '0;
      for (int i = 0; i < NUM_KEYS; i++) begin
         cnt_next[i] = (key_bits[i] && cnt_ff[i] != 8'hff) ? cnt_ff[i] + 8'd1 : cnt_ff[i];
         hit[i]      = key_bits[i] && (cnt_next[i] > cfg.threshold) && !flag_ff[i];
         if (hit[i] && taken != 2'(MAX_RES)) begin
            ev_mask[i] = 1'b1;
            taken      = taken + 2'd1;
         end
      end
   end

   assign low  = pend_ff & (~pend_ff + NUM_KEYS'(1));
   assign rest = pend_ff & ~low;
   always_comb begin
      kidx = '0;
      for (int i = 0; i < NUM_KEYS; i++) begin
         if (low[i]) begin
            kidx = 2'(i);
         end
      end
   end

   always_comb begin
      pop       = 1'b0;
      emit      = 1'b0;
      store_pts = 1'b0;
      res       = '0;
      step_in   = step_ff;
      phase_in  = phase_ff;
      pend_in   = pend_ff;
      cnt_in    = cnt_ff;
      flag_in   = flag_ff;
      timer_in  = timer_ff;
      fcount_in = fcount_ff;
      if (head_valid) begin
         case (head.op)
            CMD_TICK: begin
               pop = 1'b1;
               if (timer_ff != '0) begin
                  timer_in = timer_ff - 16'd1;
                  if (timer_ff == 16'd1) begin
                     cnt_in  = '0;
                     flag_in = '0;
                  end
               end
            end
            CMD_ERROR: begin
               if (out_free) begin
                  emit     = 1'b1;
                  pop      = 1'b1;
                  res.kind = EV_ERROR;
                  res.last = 1'b1;
               end
            end
            CMD_TOUCH: begin
               if (out_free) begin
                  emit       = 1'b1;
                  res.kind   = EV_PRESS;
                  res.finger = step_ff;
                  res.x      = step_ff ? x1 : {1'b0, x0};
                  res.y      = step_ff ? py1 : py0;
                  res.last   = step_ff || !two;
                  if (res.last) begin
                     pop       = 1'b1;
                     store_pts = 1'b1;
                     step_in   = 1'b0;
                     fcount_in = two ? 2'd2 : 2'd1;
                  end else begin
                     step_in = 1'b1;
                  end
               end
            end
            CMD_RELEASE: begin
               if (fcount_ff == 2'd0) begin
                  pop = 1'b1;
               end else if (out_free) begin
                  emit       = 1'b1;
                  res.kind   = EV_RELEASE;
                  res.finger = step_ff;
                  res.x      = sx_ff[step_ff];
                  res.y      = sy_ff[step_ff];
                  res.last   = ({1'b0, step_ff} == fcount_ff - 2'd1);
                  if (res.last) begin
                     pop     = 1'b1;
                     step_in = 1'b0;
                  end else begin
                     step_in = 1'b1;
                  end
               end
            end
            CMD_BUTTON: begin
               if (!phase_ff) begin
                  timer_in = (cfg.timeout == '0) ? 16'd1 : cfg.timeout;
                  cnt_in   = cnt_next;
                  flag_in  = flag_ff | hit;
                  pend_in  = ev_mask;
                  if (ev_mask == '0) begin
                     pop = 1'b1;
                  end else begin
                     phase_in = 1'b1;
                  end
               end else if (out_free) begin
                  emit     = 1'b1;
                  res.kind = EV_KEY;
                  res.key  = kidx;
                  res.last = (rest == '0);
                  pend_in  = rest;
                  if (res.last) begin
                     pop      = 1'b1;
                     phase_in = 1'b0;
                  end
               end
            end
            default: begin
               pop = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= 1'b0;
         phase_ff     <= 1'b0;
         pend_ff      <= '0;
         cnt_ff       <= '0;
         flag_ff      <= '0;
         timer_ff     <= '0;
         fcount_ff    <= '0;
         sx_ff[0]     <= '0;
         sx_ff[1]     <= '0;
         sy_ff[0]     <= '0;
         sy_ff[1]     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff   <= step_in;
         phase_ff  <= phase_in;
         pend_ff   <= pend_in;
         cnt_ff    <= cnt_in;
         flag_ff   <= flag_in;
         timer_ff  <= timer_in;
         fcount_ff <= fcount_in;
         if (store_pts) begin
            sx_ff[0] <= {1'b0, x0};
            sy_ff[0] <= py0;
            sx_ff[1] <= x1;
            sy_ff[1] <= py1;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff <= res;
      end
   end

endmodule

@@ src/touch_report_packet_decoder.sv @@
// channel  direction  tdata (low bit up)                         tuser / tlast
// req_     in         packet_byte[7:0]                           opcode, packet_start
// rsp_     out        finger_index, pos_x[12:0], pos_y[15:0],    event_kind[1:0] /
//                     key_index[1:0]                             last_of_run
// csr_     in         index 0 threshold, 1 timeout, 2 y max      write only
//
// One request a cycle while the queue has room; a report's results leave one a cycle
// while rsp_tready is high, via the command queue and result register. A button report
// updates its key counters before its key events. A two-entry command queue sits between
// byte framing and the event sequencer; req_tready drops only while it is full.
// Reset is synchronous: framing, stored points, key counts, timer and queue clear,
// registers return to their defaults.
module touch_report_packet_decoder #(
   parameter int NUM_KEYS = tpd_pkg::NUM_KEYS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // packet_byte[7:0]
   input  logic [1:0]  req_tuser,   // opcode, packet_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // finger_index, pos_x[12:0], pos_y[15:0], key_index[1:0]
   output logic [1:0]  rsp_tuser,   // event_kind[1:0]
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import tpd_pkg::*;

   cfg_type    cfg_ff;
   logic       accept, push, pop;
   cmd_type    cmd, head;
   q_stat_type q_stat;
   res_type    rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold <= THRESHOLD_RST;
         cfg_ff.timeout   <= TIMEOUT_RST;
         cfg_ff.y_max     <= Y_MAX_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_THRESHOLD: cfg_ff.threshold <= csr_wdata[7:0];
            CSR_TIMEOUT:   cfg_ff.timeout   <= csr_wdata;
            CSR_Y_MAX:     cfg_ff.y_max     <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   assign req_tready = !q_stat.full;
   assign accept     = req_tvalid && req_tready;

   tpd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .opcode       (req_tuser[0]),
      .packet_byte  (req_tdata),
      .packet_start (req_tuser[1]),
      .push         (push),
      .cmd          (cmd)
   );

   tpd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (cmd),
      .pop      (pop),
      .head     (head),
      .stat     (q_stat)
   );

   tpd_back #(
      .NUM_KEYS (NUM_KEYS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (q_stat.valid),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tdata = {rsp.key, rsp.y, rsp.x, rsp.finger};
   assign rsp_tuser = rsp.kind;
   assign rsp_tlast = rsp.last;

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_stat.count <= QCNT_W'(QUEUE_DEPTH))
      else $error("command queue overfilled");

   a_error_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == EV_ERROR |-> rsp_tlast && rsp_tdata == '0)
      else $error("error result not a lone empty request");

   a_key_no_point: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == EV_KEY |-> rsp_tdata[29:0] == '0)
      else $error("key result carries point fields");

   a_point_no_key: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == EV_PRESS || rsp_tuser == EV_RELEASE)
      |-> rsp_tdata[31:30] == '0)
      else $error("point result carries key index");

endmodule

@@ bench/touch_report_packet_decoder_tb.sv @@
module touch_report_packet_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tpd_pkg::*;

   class event_scoreboard;
      logic [7:0]  threshold;
      logic [15:0] timeout_ticks;
      logic [11:0] y_max;
      logic [2:0]  byte_pos;
      logic [7:0]  report [REPORT_LEN];
      logic [7:0]  sum;
      logic [15:0] points [4];
      int          finger_count;
      logic [7:0]  presses [NUM_KEYS_DEFAULT];
      bit          key_sent [NUM_KEYS_DEFAULT];
      logic [15:0] ticks_left;
      res_type     pending_events [$];
      int          errors;

      function new();
         threshold     = THRESHOLD_RST;
         timeout_ticks = TIMEOUT_RST;
         y_max         = Y_MAX_RST;
         byte_pos      = 3'd0;
         sum           = 8'h00;
         finger_count  = 0;
         ticks_left    = 16'd0;
         errors        = 0;
         foreach (report[i]) report[i] = 8'h00;
         foreach (points[i]) points[i] = 16'h0000;
         clear_keys();
      endfunction

      function void clear_keys();
         foreach (presses[i]) begin
            presses[i]  = 8'h00;
            key_sent[i] = 1'b0;
         end
      endfunction

      function void set_reg(logic [1:0] index, logic [15:0] value);
         case (index)
            CSR_THRESHOLD: begin
               threshold = value[7:0];
            end
            CSR_TIMEOUT: begin
               timeout_ticks = value;
            end
            CSR_Y_MAX: begin
               y_max = value[11:0];
            end
            default: ;
         endcase
      endfunction

      function void note_request(bit tick, logic [7:0] data, bit start);
         res_type     ev;
         res_type     found [$];
         logic [2:0]  pos;
         logic [7:0]  check;
         logic [15:0] x0, y0, x1, y1, mag;
         int          nf;
         if (tick) begin
            if (ticks_left != 16'd0) begin
               ticks_left--;
               if (ticks_left == 16'd0) clear_keys();
            end
            return;
         end
         pos = start ? 3'd0 : byte_pos;
         report[pos] = data;
         if (pos == 3'd0) sum = data;
         else if (pos != REPORT_LEN - 1) sum = sum + data;
         if (pos != REPORT_LEN - 1) begin
            byte_pos = pos + 3'd1;
            return;
         end
         byte_pos = 3'd0;
         check = 8'h00 - sum;
         if (report[0] != HDR_BYTE || check != report[7]) begin
            ev = '0;
            ev.kind = EV_ERROR;
            found.push_back(ev);
         end else if (report[1] == FILL_BYTE && report[2] == FILL_BYTE &&
                      report[3] == FILL_BYTE && report[4] == 8'h00 &&
                      report[6] == FILL_BYTE) begin
            if (report[5] != 8'h00) begin
               ticks_left = (timeout_ticks == 16'd0) ? 16'd1 : timeout_ticks;
               for (int i = 0; i < NUM_KEYS_DEFAULT; i++) begin
                  if (report[5][i]) begin
                     if (presses[i] != 8'hff) presses[i]++;
                     if (presses[i] > threshold && !key_sent[i]) begin
                        key_sent[i] = 1'b1;
                        ev = '0;
                        ev.kind = EV_KEY;
                        ev.key = i[1:0];
                        found.push_back(ev);
                     end
                  end
               end
            end else begin
               for (int i = 0; i < finger_count; i++) begin
                  ev = '0;
                  ev.kind   = EV_RELEASE;
                  ev.finger = i[0];
                  ev.x      = points[2*i][12:0];
                  ev.y      = points[2*i+1];
                  found.push_back(ev);
               end
            end
         end else begin
            x0 = {4'h0, report[1][7:4], report[2]};
            y0 = {4'h0, report[1][3:0], report[3]};
            x1 = {4'h0, report[4][7:4], report[5]};
            y1 = {4'h0, report[4][3:0], report[6]};
            nf = (x1 == 16'd0 && y1 == 16'd0) ? 1 : 2;
            x1 = x1 + x0;
            // second Y is a delta, bit 11 flags a negative one
            if (y1[11]) begin
               mag = {5'h00, ~y1[10:0]} + 16'd1;
               y1  = y0 - mag;
            end else begin
               y1 = y1 + y0;
            end
            points[0] = x0;
            points[1] = {4'h0, y_max} - y0;
            points[2] = x1;
            points[3] = {4'h0, y_max} - y1;
            finger_count = nf;
            for (int i = 0; i < nf; i++) begin
               ev = '0;
               ev.kind   = EV_PRESS;
               ev.finger = i[0];
               ev.x      = points[2*i][12:0];
               ev.y      = points[2*i+1];
               found.push_back(ev);
            end
         end
         if (found.size() != 0) found[found.size()-1].last = 1'b1;
         foreach (found[i]) pending_events.push_back(found[i]);
      endfunction

      task report_mismatch(string msg);
         errors++;
         if (errors <= 100) $display("mismatch at %0t ns: %s", $time, msg);
      endtask

      task check_event(res_type got);
         res_type want;
         if (pending_events.size() == 0) begin
            report_mismatch($sformatf("unexpected event, kind %0d", got.kind));
            return;
         end
         want = pending_events.pop_front();
         if (got.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
         if (got.finger !== want.finger)
            report_mismatch($sformatf("finger %0d, want %0d", got.finger, want.finger));
         if (got.x !== want.x)
            report_mismatch($sformatf("x %0d, want %0d", got.x, want.x));
         if (got.y !== want.y)
            report_mismatch($sformatf("y %0d, want %0d", got.y, want.y));
         if (got.key !== want.key)
            report_mismatch($sformatf("key %0d, want %0d", got.key, want.key));
         if (got.last !== want.last)
            report_mismatch($sformatf("last %0d, want %0d", got.last, want.last));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // packet_byte[7:0]
   logic [1:0]  req_tuser = 2'b00;   // opcode, packet_start
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [31:0] rsp_tdata;           // finger_index, pos_x[12:0], pos_y[15:0], key_index[1:0]
   logic [1:0]  rsp_tuser;           // event_kind[1:0]
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_THRESHOLD;
   logic [15:0] csr_wdata = 16'h0000;

   event_scoreboard sb;
   logic [7:0]      frame [REPORT_LEN];
   int              sent_items = 0;
   bit              idling_on = 1'b1;
   bit              ticks_on = 1'b0;
   bit              long_hold_request = 1'b0;

   touch_report_packet_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic send_request(bit tick, logic [7:0] data, bit start);
      if (idling_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= {start, tick};
      do @(posedge clock); while (!req_tready);
      sb.note_request(tick, data, start);
      sent_items++;
   endtask

   task automatic send_byte(logic [7:0] data, bit start);
      if (ticks_on && $urandom_range(0, 7) == 0)
         send_request(1'b1, 8'($urandom), 1'($urandom));
      send_request(1'b0, data, start);
   endtask

   function automatic void set_frame(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                     logic [7:0] b3, logic [7:0] b4, logic [7:0] b5,
                                     logic [7:0] b6);
      frame[0] = b0;
      frame[1] = b1;
      frame[2] = b2;
      frame[3] = b3;
      frame[4] = b4;
      frame[5] = b5;
      frame[6] = b6;
   endfunction

   task automatic send_frame(bit first_start, bit spoil_sum);
      logic [7:0] total;
      total = 8'h00;
      for (int i = 0; i < REPORT_LEN - 1; i++) total = total + frame[i];
      frame[REPORT_LEN-1] = 8'h00 - total;
      if (spoil_sum) frame[REPORT_LEN-1] = frame[REPORT_LEN-1] ^ 8'($urandom_range(1, 255));
      for (int i = 0; i < REPORT_LEN; i++) send_byte(frame[i], (i == 0) ? first_start : 1'b0);
   endtask

   task automatic write_reg(logic [1:0] index, logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      sb.set_reg(index, value);
   endtask

   // registers change only with the block drained and quiet
   task automatic set_config(logic [7:0] thr, logic [15:0] ticks, logic [11:0] ymax);
      req_tvalid <= 1'b0;
      while (sb.pending_events.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      write_reg(CSR_THRESHOLD, {8'h00, thr});
      write_reg(CSR_TIMEOUT, ticks);
      write_reg(CSR_Y_MAX, {4'h0, ymax});
      csr_we <= 1'b0;
   endtask

   task automatic random_report();
      int         pick;
      int         n;
      bit         first_start;
      logic [7:0] keys;
      pick = $urandom_range(0, 99);
      first_start = ($urandom_range(0, 9) != 0);
      if (pick < 45) begin
         set_frame(HDR_BYTE, 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom), 8'($urandom), 8'($urandom));
         if ($urandom_range(0, 3) == 0) begin
            frame[4] = 8'h00;
            frame[5] = 8'h00;
            frame[6] = 8'h00;
         end
         send_frame(first_start, 1'b0);
      end else if (pick < 55) begin
         set_frame(HDR_BYTE, FILL_BYTE, FILL_BYTE, FILL_BYTE, 8'h00, 8'h00, FILL_BYTE);
         send_frame(first_start, 1'b0);
      end else if (pick < 80) begin
         if ($urandom_range(0, 3) == 0) keys = 8'($urandom_range(1, 255));
         else keys = {5'($urandom), 3'($urandom_range(1, 7))};
         set_frame(HDR_BYTE, FILL_BYTE, FILL_BYTE, FILL_BYTE, 8'h00, keys, FILL_BYTE);
         send_frame(first_start, 1'b0);
      end else if (pick < 90) begin
         set_frame(HDR_BYTE, 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom), 8'($urandom), 8'($urandom));
         if ($urandom_range(0, 1) == 0) begin
            frame[0] = 8'($urandom);
            if (frame[0] == HDR_BYTE) frame[0] = frame[0] ^ 8'($urandom_range(1, 255));
            send_frame(first_start, 1'b0);
         end else begin
            send_frame(first_start, 1'b1);
         end
      end else begin
         // stray bytes, may leave framing mid-report
         n = $urandom_range(1, 7);
         for (int i = 0; i < n; i++)
            send_byte(8'($urandom), (i == 0) ? 1'b1 : ($urandom_range(0, 5) == 0));
      end
   endtask

   task automatic run_mixed(int count);
      int first;
      first = sent_items;
      while (sent_items - first < count) random_report();
   endtask

   initial begin
      res_type got;
      int      stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            got.kind   = event_kind_type'(rsp_tuser);
            got.finger = rsp_tdata[0];
            got.x      = rsp_tdata[13:1];
            got.y      = rsp_tdata[29:14];
            got.key    = rsp_tdata[31:30];
            got.last   = rsp_tlast;
            sb.check_event(got);
         end
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            stall_left = 80;
         end
         if (stall_left == 0 && idling_on && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 4);
         if (stall_left != 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int wait_cycles;
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      set_config(8'd1, 16'd2, 12'd4095);
      // release with nothing stored
      set_frame(HDR_BYTE, FILL_BYTE, FILL_BYTE, FILL_BYTE, 8'h00, 8'h00, FILL_BYTE);
      send_frame(1'b1, 1'b0);
      // one finger at the far corner
      set_frame(HDR_BYTE, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00);
      send_frame(1'b1, 1'b0);
      // largest positive delta
      set_frame(HDR_BYTE, 8'h00, 8'h00, 8'h00, 8'hf7, 8'hff, 8'hff);
      send_frame(1'b1, 1'b0);
      // largest negative delta, Y wraps
      set_frame(HDR_BYTE, 8'hf0, 8'hff, 8'h00, 8'hf8, 8'hff, 8'h00);
      send_frame(1'b1, 1'b0);
      set_frame(HDR_BYTE, FILL_BYTE, FILL_BYTE, FILL_BYTE, 8'h00, 8'h00, FILL_BYTE);
      send_frame(1'b1, 1'b0);
      // bad header, then bad checksum
      set_frame(8'ha5, 8'h12, 8'h34, 8'h56, 8'h00, 8'h00, 8'h00);
      send_frame(1'b1, 1'b0);
      set_frame(HDR_BYTE, 8'h12, 8'h34, 8'h56, 8'h00, 8'h00, 8'h00);
      send_frame(1'b1, 1'b1);
      // buttons: at, then past the threshold
      set_frame(HDR_BYTE, FILL_BYTE, FILL_BYTE, FILL_BYTE, 8'h00, 8'h07, FILL_BYTE);
      send_frame(1'b1, 1'b0);
      set_frame(HDR_BYTE, FILL_BYTE, FILL_BYTE, FILL_BYTE, 8'h00, 8'h03, FILL_BYTE);
      send_frame(1'b1, 1'b0);
      set_frame(HDR_BYTE, FILL_BYTE, FILL_BYTE, FILL_BYTE, 8'h00, 8'hff, FILL_BYTE);
      send_frame(1'b1, 1'b0);
      // timeout expires and clears the counts
      send_request(1'b1, 8'hff, 1'b1);
      send_request(1'b1, 8'h00, 1'b0);
      set_frame(HDR_BYTE, FILL_BYTE, FILL_BYTE, FILL_BYTE, 8'h00, 8'h01, FILL_BYTE);
      send_frame(1'b1, 1'b0);
      // cut-off report, resync on the next start
      send_byte(HDR_BYTE, 1'b1);
      send_byte(8'h11, 1'b0);
      send_byte(8'h22, 1'b0);
      set_frame(HDR_BYTE, 8'h12, 8'h34, 8'h56, 8'h00, 8'h00, 8'h00);
      send_frame(1'b1, 1'b0);
      // aligned report without start flag, ticks mixed in
      ticks_on = 1'b1;
      set_frame(HDR_BYTE, 8'h80, 8'h00, 8'h01, 8'h0f, 8'h00, 8'h01);
      send_frame(1'b0, 1'b0);

      set_config(8'd0, 16'd1, 12'd2047);
      run_mixed(18);

      set_config(8'd255, 16'd0, 12'($urandom));
      long_hold_request = 1'b1;
      run_mixed(14);

      set_config(8'($urandom_range(0, 7)), 16'($urandom_range(1, 20)), 12'd4095);
      idling_on = 1'b0;
      run_mixed(14);

      req_tvalid <= 1'b0;
      wait_cycles = 0;
      while (sb.pending_events.size() != 0 && wait_cycles < 2000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (20) @(posedge clock);
      if (sb.pending_events.size() != 0)
         sb.report_mismatch($sformatf("%0d events never arrived", sb.pending_events.size()));
      if (sb.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
